@@ rtl/psd_pkg.sv @@
// Package for the pairwise squared distance engine: sizes, opcodes, helpers.
// No dependencies.
`default_nettype none
package psd_pkg;
  localparam int unsigned MaxVectors = 64;
  localparam int unsigned MaxLen     = 64;

  localparam logic [1:0] OpLoadA   = 2'd0;
  localparam logic [1:0] OpLoadB   = 2'd1;
  localparam logic [1:0] OpCompute = 2'd2;
  localparam logic [1:0] OpUnused  = 2'd3;

  localparam logic [1:0] RegVecLen  = 2'd0;
  localparam logic [1:0] RegCountA  = 2'd1;
  localparam logic [1:0] RegCountB  = 2'd2;
  localparam logic [1:0] RegSelf    = 2'd3;

  // Control handed down the cell chain with each operand pair.
  typedef struct packed {
    logic       valid;
    logic       first;  // first component of a row
    logic       fin;    // last component of a row
    logic [5:0] row;
    logic       last;   // last row of the column
  } psd_tag_t;

  function automatic logic [6:0] clamp7(logic [6:0] v, logic [6:0] hi);
    return (v > hi) ? hi : v;
  endfunction
endpackage
`default_nettype wire

@@ rtl/psd_cell.sv @@
// One cell of the distance chain: subtract, square or accumulate stage.
// Depends on psd_pkg.
`default_nettype none
module psd_cell #(
  parameter int unsigned Kind = 0  // 0 subtract, 1 square, 2 accumulate
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire psd_pkg::psd_tag_t tag_i,
  input  wire logic [31:0]      x_i,
  input  wire logic [31:0]      y_i,
  output psd_pkg::psd_tag_t     tag_o,
  output logic [31:0]           x_o,
  output logic [31:0]           y_o
);
  logic [31:0] x_d;
  logic [63:0] prod;

  assign prod = 64'(x_i) * 64'(x_i);

  always_comb begin
    case (Kind)
      0:       x_d = y_i - x_i;
      1:       x_d = prod[31:0];
      default: x_d = tag_i.first ? x_i : x_o + x_i;
    endcase
  end

  // en_i low freezes the cell in place
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && tag_i.valid) begin
      x_o <= x_d;
      y_o <= y_i;
    end
  end
endmodule
`default_nettype wire

@@ rtl/pairwise_squared_distance.sv @@
// Top level of the pairwise squared distance engine: stores, sequencer, chain.
// Depends on psd_pkg and psd_cell.
//
//  channel | dir | fields (tdata low bit up)
//  s_axis  | in  | op[1:0] vector_index[7:2] component[13:8] value[45:14], pad
//  m_axis  | out | distance[31:0] row_index[37:32] column_index[43:38]; tlast
//  cfg     | in  | cfg_index_i, cfg_data_i
//
// A compute streams count_a*vec_len operand pairs (count_a pairs when vec_len
// is 0), one per cycle while the output is not stalled, from the store read
// ports, through a three-cell chain (subtract, square, accumulate); the next
// beat is taken only once the sequencer is idle and t0 and the chain are empty.
// Reset clears control only; stores hold garbage until loaded.
// While the output register is full and not taken, sequencer and chain freeze.
`default_nettype none
module pairwise_squared_distance (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // op, vector_index, component, value
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // distance, row_index, column_index
  output logic             m_axis_tlast
);
  localparam int unsigned AW = 12;
  localparam int unsigned Depth = psd_pkg::MaxVectors * psd_pkg::MaxLen;

  logic [1:0]  op;
  logic [5:0]  vi, comp;
  logic [31:0] val;
  assign op   = s_axis_tdata[1:0];
  assign vi   = s_axis_tdata[7:2];
  assign comp = s_axis_tdata[13:8];
  assign val  = s_axis_tdata[45:14];

  logic [6:0] len_q, ca_q, cb_q;
  logic       self_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 7'd1; ca_q <= 7'd1; cb_q <= 7'd1; self_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psd_pkg::RegVecLen: len_q  <= cfg_data_i;
        psd_pkg::RegCountA: ca_q   <= cfg_data_i;
        psd_pkg::RegCountB: cb_q   <= cfg_data_i;
        default:            self_q <= cfg_data_i[0];
      endcase
    end
  end

  logic [6:0] len, rows, cols;
  assign len  = psd_pkg::clamp7(len_q, 7'(psd_pkg::MaxLen));
  assign rows = psd_pkg::clamp7(ca_q, 7'(psd_pkg::MaxVectors));
  assign cols = self_q ? rows : psd_pkg::clamp7(cb_q, 7'(psd_pkg::MaxVectors));

  // Sequencer
  logic       busy_q, zl_q;
  logic [5:0] col_q, row_q, l_q, rowm_q, lenm_q;
  logic       out_full, stall, issue;
  logic       pipe_busy;
  psd_pkg::psd_tag_t t0, t1, t2, t3;

  assign stall = m_axis_tvalid && !m_axis_tready;
  assign pipe_busy = t1.valid || t2.valid || t3.valid;
  assign s_axis_tready = !busy_q && !pipe_busy && !t0.valid;
  assign issue = busy_q && !stall;
  assign out_full = 1'b0;

  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; zl_q <= 1'b0;
      col_q <= '0; row_q <= '0; l_q <= '0; rowm_q <= '0; lenm_q <= '0;
    end else if (acc_in) begin
      if (op == psd_pkg::OpCompute && {1'b0, vi} < cols && rows != 7'd0) begin
        busy_q <= 1'b1;
        col_q  <= vi; row_q <= '0; l_q <= '0;
        rowm_q <= 6'(rows - 7'd1);
        zl_q   <= (len == 7'd0);
        lenm_q <= (len == 7'd0) ? 6'd0 : 6'(len - 7'd1);
      end
    end else if (issue) begin
      if (l_q == lenm_q) begin
        l_q <= '0;
        if (row_q == rowm_q) busy_q <= 1'b0;
        row_q <= row_q + 6'd1;
      end else begin
        l_q <= l_q + 6'd1;
      end
    end
  end

  // Stores
  logic [31:0] mem_a [Depth];
  logic [31:0] mem_b [Depth];
  logic [31:0] ra_q, rb_q, rab_q;
  logic        selb_q;
  logic [AW-1:0] wa;
  assign wa = {vi, comp};
  always_ff @(posedge clk_i) begin
    if (acc_in && op == psd_pkg::OpLoadA) mem_a[wa] <= val;
    if (acc_in && op == psd_pkg::OpLoadB) mem_b[wa] <= val;
    if (issue) begin
      ra_q  <= mem_a[{row_q, l_q}];
      rab_q <= mem_a[{col_q, l_q}];
      rb_q  <= mem_b[{col_q, l_q}];
    end
    if (acc_in) selb_q <= !self_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0 <= '0;
    end else if (!stall) begin
      t0.valid <= issue;
      t0.first <= (l_q == 6'd0);
      t0.fin   <= (l_q == lenm_q);
      t0.row   <= row_q;
      t0.last  <= (row_q == rowm_q);
    end
  end

  // Chain advances only when the output register can move; a stall parks
  // every beat in place together with the store read data and t0.
  logic        adv;
  logic [31:0] x1, y1, x2, y2, x3, y3, bsel, a0, b0;
  assign adv  = !stall;
  assign bsel = selb_q ? rb_q : rab_q;
  assign a0 = zl_q ? 32'd0 : ra_q;
  assign b0 = zl_q ? 32'd0 : bsel;
  psd_cell #(.Kind(0)) u_sub (.clk_i, .rst_ni, .en_i(adv), .tag_i(t0), .x_i(a0),
    .y_i(b0), .tag_o(t1), .x_o(x1), .y_o(y1));
  psd_cell #(.Kind(1)) u_sq (.clk_i, .rst_ni, .en_i(adv), .tag_i(t1), .x_i(x1),
    .y_i(y1), .tag_o(t2), .x_o(x2), .y_o(y2));
  psd_cell #(.Kind(2)) u_acc (.clk_i, .rst_ni, .en_i(adv), .tag_i(t2), .x_i(x2),
    .y_i(y2), .tag_o(t3), .x_o(x3), .y_o(y3));

  // Output register
  logic [31:0] dist_q;
  logic [5:0]  orow_q, ocol_q;
  logic        olast_q, ovalid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (!stall) begin
      ovalid_q <= t3.valid && t3.fin;
    end
  end
  always_ff @(posedge clk_i) begin
    if (!stall && t3.valid && t3.fin) begin
      dist_q <= x3; orow_q <= t3.row; ocol_q <= col_q; olast_q <= t3.last;
    end
  end
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, ocol_q, orow_q, dist_q};
  assign m_axis_tlast  = olast_q;

  logic unused;
  assign unused = out_full ^ (^y3);
endmodule
`default_nettype wire
